[hw/rtl/ksm_pkg.sv]
package ksm_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 6;

  localparam logic [7:0] MAX_KEY     = 8'hFE;
  localparam logic [7:0] SCAN_RSHIFT = 8'h36;

  localparam logic [7:0] K_SHIFT    = 8'h10;
  localparam logic [7:0] K_CONTROL  = 8'h11;
  localparam logic [7:0] K_ALT      = 8'h12;
  localparam logic [7:0] K_LSHIFT   = 8'hA0;
  localparam logic [7:0] K_RSHIFT   = 8'hA1;
  localparam logic [7:0] K_LCONTROL = 8'hA2;
  localparam logic [7:0] K_RCONTROL = 8'hA3;
  localparam logic [7:0] K_LALT     = 8'hA4;
  localparam logic [7:0] K_RALT     = 8'hA5;

  localparam logic [31:0] SHIFT_PAIR_MASK = 32'h0000_0003;

  typedef enum logic [2:0] {
    CMD_PRESS    = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_ACTIVATE = 3'd2,
    CMD_LEVEL    = 3'd3,
    CMD_TRIGGER  = 3'd4,
    CMD_RELQUERY = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic        clear_all;
    logic        write_en;
    logic        set;
    logic [2:0]  word;
    logic [31:0] mask;
  } map_op_t;

  typedef struct packed {
    logic store_en;
    logic drop_en;
  } slot_op_t;

endpackage

[hw/rtl/ksm_slot_cell.sv]
module ksm_slot_cell
  import ksm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] key,
  input  slot_op_t   op,
  input  logic       match_in,
  input  logic       empty_in,
  input  logic       any_match,
  output logic       match_out,
  output logic       empty_out
);

  logic [7:0] slot_r;
  logic [7:0] slot_nxt;
  logic       match;
  logic       empty;

  assign match     = (slot_r == key);
  assign empty     = (slot_r == 8'h00);
  assign match_out = match_in | match;
  assign empty_out = empty_in | empty;

  always_comb begin
    slot_nxt = slot_r;
    if (op.drop_en && match && !match_in) begin
      slot_nxt = 8'h00;
    end else if (op.store_en && !any_match && empty && !empty_in) begin
      slot_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 8'h00;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

[hw/rtl/ksm_key_map.sv]
module ksm_key_map
  import ksm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  map_op_t     op,
  input  logic [2:0]  rd_word,
  output logic [31:0] rd_data
);

  logic [31:0] map_r   [8];
  logic [31:0] map_nxt [8];

  assign rd_data = map_r[rd_word];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      map_nxt[i] = map_r[i];
    end
    if (op.clear_all) begin
      for (int i = 0; i < 8; i++) begin
        map_nxt[i] = 32'h0;
      end
    end else if (op.write_en) begin
      if (op.set) begin
        map_nxt[op.word] = map_r[op.word] | op.mask;
      end else begin
        map_nxt[op.word] = map_r[op.word] & ~op.mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        map_r[i] <= 32'h0;
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        map_r[i] <= map_nxt[i];
      end
    end
  end

endmodule

[hw/rtl/key_state_map_with_edge_slots.sv]
// A word is taken while idle and its result is registered once the output is free; no new
// word is taken until then. The map read-modify-write and the slot chain settle in the
// execute state, and a stalled output holds that state.
// Reset: synchronous, active low; clears the key map, empties all slots and drops any
// pending result.
module key_state_map_with_edge_slots
  import ksm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[2:0], key_code[10:3], scan_code[18:11], extended[19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // is_down[0], is_up[1], edge_res[2]
);

  state_t      state_r;
  state_t      state_nxt;
  cmd_t        cmd_r;
  logic [7:0]  key_r;
  logic        shift_rel_r;
  logic        out_valid_r;
  logic [2:0]  out_data_r;

  cmd_t        in_cmd;
  logic [7:0]  in_key;
  logic [7:0]  in_scan;
  logic        in_ext;
  logic [7:0]  key_mapped;
  logic        in_fire;
  logic        exec_fire;
  logic        out_free;

  map_op_t     map_op;
  slot_op_t    slot_op;
  logic [31:0] rd_data;
  logic        valid_key;
  logic        lvl;
  logic        is_query;
  logic        is_down;
  logic        is_up;
  logic        edge_res;
  logic        stored;
  logic        dropped;

  logic [SLOT_COUNT:0] match_c;
  logic [SLOT_COUNT:0] empty_c;

  assign in_cmd  = cmd_t'(in_tdata[2:0]);
  assign in_key  = in_tdata[10:3];
  assign in_scan = in_tdata[18:11];
  assign in_ext  = in_tdata[19];
  assign in_fire = in_tvalid && in_tready;

  // split generic modifiers for events only
  always_comb begin
    key_mapped = in_key;
    if (in_cmd == CMD_PRESS || in_cmd == CMD_RELEASE) begin
      case (in_key)
        K_SHIFT:   key_mapped = (in_scan == SCAN_RSHIFT) ? K_RSHIFT : K_LSHIFT;
        K_CONTROL: key_mapped = in_ext ? K_RCONTROL : K_LCONTROL;
        K_ALT:     key_mapped = in_ext ? K_RALT : K_LALT;
        default:   key_mapped = in_key;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_cmd;
      key_r       <= key_mapped;
      shift_rel_r <= (in_cmd == CMD_RELEASE) && (in_key == K_SHIFT);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    in_tready = 1'b0;
    exec_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: exec_fire = out_free;
      default: begin
        in_tready = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign valid_key = (key_r <= MAX_KEY);
  assign lvl       = valid_key && rd_data[key_r[4:0]];
  assign is_query  = (cmd_r == CMD_LEVEL) || (cmd_r == CMD_TRIGGER) || (cmd_r == CMD_RELQUERY);

  always_comb begin
    map_op.clear_all = exec_fire && (cmd_r == CMD_ACTIVATE);
    map_op.write_en  = exec_fire && valid_key &&
                       ((cmd_r == CMD_PRESS) || (cmd_r == CMD_RELEASE));
    map_op.set       = (cmd_r == CMD_PRESS);
    map_op.word      = key_r[7:5];
    map_op.mask      = shift_rel_r ? SHIFT_PAIR_MASK : (32'h1 << key_r[4:0]);
  end

  ksm_key_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (map_op),
    .rd_word (key_r[7:5]),
    .rd_data (rd_data)
  );

  always_comb begin
    slot_op.store_en = exec_fire && (key_r != 8'h00) && lvl &&
                       ((cmd_r == CMD_TRIGGER) || (cmd_r == CMD_RELQUERY));
    slot_op.drop_en  = exec_fire && (key_r != 8'h00) && !lvl &&
                       ((cmd_r == CMD_TRIGGER) || (cmd_r == CMD_RELQUERY));
  end

  assign match_c[0] = 1'b0;
  assign empty_c[0] = 1'b0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    ksm_slot_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key       (key_r),
      .op        (slot_op),
      .match_in  (match_c[g]),
      .empty_in  (empty_c[g]),
      .any_match (match_c[SLOT_COUNT]),
      .match_out (match_c[g+1]),
      .empty_out (empty_c[g+1])
    );
  end

  assign stored   = !match_c[SLOT_COUNT] && empty_c[SLOT_COUNT];
  assign dropped  = match_c[SLOT_COUNT];
  assign is_down  = is_query && valid_key && lvl;
  assign is_up    = is_query && valid_key && !lvl;
  assign edge_res = (slot_op.store_en && (cmd_r == CMD_TRIGGER) && stored) ||
                    (slot_op.drop_en && (cmd_r == CMD_RELQUERY) && dropped);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= {edge_res, is_up, is_down};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while another is in flight");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_tvalid)
    else $error("executed word left no result");

  a_level_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("key reported both down and up");

  a_edge_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> (out_tdata[0] || out_tdata[1]))
    else $error("edge reported without a valid query");
`endif

endmodule
